[design/utf8_text_field_checker_macros.svh]
// Assertion macros for the UTF-8 text field checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef UTF8_TEXT_FIELD_CHECKER_MACROS_SVH
`define UTF8_TEXT_FIELD_CHECKER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTF8TFC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("utf8tfc: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define UTF8TFC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("utf8tfc: next-cycle check failed");

`endif

[design/utf8tfc_pkg.sv]
// Package for the UTF-8 text field checker: widths, register indexes,
// string state type and the whitespace test. No dependencies.
package utf8tfc_pkg;

  localparam int unsigned CpW    = 21;
  localparam int unsigned UnitW  = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  localparam logic [CfgIdxW-1:0] RegUnitLimit  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegAllowLines = 2'd1;
  localparam logic [CfgIdxW-1:0] RegReqContent = 2'd2;

  localparam logic [UnitW-1:0] UnitLimitReset = 16'd200;
  localparam logic [UnitW-1:0] UnitMax        = 16'hFFFF;

  localparam logic [CpW-1:0] CpDel      = 21'd127;
  localparam logic [CpW-1:0] CpTab      = 21'd9;
  localparam logic [CpW-1:0] CpLf       = 21'd10;
  localparam logic [CpW-1:0] CpCr       = 21'd13;
  localparam logic [CpW-1:0] CpSuppBase = 21'h10000;

  typedef struct packed {
    logic [1:0]       pending;
    logic [CpW-1:0]   acc;
    logic [UnitW-1:0] units;
    logic             failed;
    logic             content;
  } str_state_t;

  typedef struct packed {
    logic [UnitW-1:0] unit_limit;
    logic             allow_lines;
    logic             req_content;
  } cfg_t;

  function automatic logic is_blank(logic [CpW-1:0] c);
    return (c inside {[21'd9:21'd13], 21'd32, 21'hA0, 21'h1680, [21'h2000:21'h200A],
                      21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000, 21'hFEFF});
  endfunction

endpackage

[design/utf8tfc_decode.sv]
// Per-byte UTF-8 decode step: next string state and end-of-string verdict.
// Depends on utf8tfc_pkg.
module utf8tfc_decode
  import utf8tfc_pkg::*;
(
  input  str_state_t st_i,
  input  cfg_t       cfg_i,
  input  logic [7:0] byte_i,
  output str_state_t st_o,
  output logic       verdict_o
);

  logic [CpW-1:0]   cp;
  logic             finish;
  logic [CpW-1:0]   acc_shift;
  logic [UnitW:0]   sum;
  logic             ctrl_ok;
  logic             bad;

  assign acc_shift = {st_i.acc[CpW-7:0], byte_i[5:0]};
  assign cp        = (st_i.pending == 2'd0) ? {13'd0, byte_i} : acc_shift;
  assign finish    = (st_i.pending == 2'd0) ? (byte_i < 8'hC0) : (st_i.pending == 2'd1);
  assign sum       = {1'b0, st_i.units} + ((cp >= CpSuppBase) ? 17'd2 : 17'd1);
  assign ctrl_ok   = cfg_i.allow_lines && (cp == CpTab || cp == CpLf || cp == CpCr);
  assign bad       = (sum > {1'b0, cfg_i.unit_limit}) || (cp == CpDel) ||
                     ((cp[CpW-1:5] == '0) && !ctrl_ok);

  assign verdict_o = !st_i.failed && (st_i.pending == 2'd0) &&
                     !(cfg_i.req_content && !st_i.content);

  always_comb begin
    st_o = st_i;
    if (!st_i.failed) begin
      if (finish) begin
        st_o.pending = 2'd0;
        st_o.acc     = '0;
        st_o.units   = sum[UnitW] ? UnitMax : sum[UnitW-1:0];
        if (bad) begin
          st_o.failed = 1'b1;
        end else if (!is_blank(cp)) begin
          st_o.content = 1'b1;
        end
      end else if (st_i.pending == 2'd0) begin
        if (byte_i < 8'hE0) begin
          st_o.pending = 2'd1;
          st_o.acc     = {16'd0, byte_i[4:0]};
        end else if (byte_i < 8'hF0) begin
          st_o.pending = 2'd2;
          st_o.acc     = {17'd0, byte_i[3:0]};
        end else begin
          st_o.pending = 2'd3;
          st_o.acc     = {18'd0, byte_i[2:0]};
        end
      end else begin
        st_o.pending = st_i.pending - 2'd1;
        st_o.acc     = acc_shift;
      end
    end
  end

endmodule

[design/utf8_text_field_checker.sv]
// Top level of the UTF-8 text field checker: config registers, string
// state register and result register. Depends on utf8tfc_pkg, utf8tfc_decode.
//
//   channel | signals                                   | direction
//   in      | in_valid_i/in_ready_o, kind, text_byte    | request in
//   out     | out_valid_o/out_ready_i, verdict fields   | request out
//   cfg     | cfg_valid_i/cfg_ready_o, index, data      | register write
//
// One request per cycle while in_ready_o is high: each byte updates the string
// state at the edge it is taken, and an end request loads the result register
// and sets out_valid_o at that same edge.
// Input is held off only while a result waits and out_ready_i is low.
// Reset restores unit_limit 200, allow_line_breaks 0, require_content 1
// and clears the string state; cfg writes are always taken.
module utf8_text_field_checker
  import utf8tfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_kind_i,
  input  logic [7:0]         in_text_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_accepted_o,
  output logic [UnitW-1:0]   out_unit_count_o,
  output logic               out_has_content_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgDatW-1:0] cfg_data_i
);

  cfg_t             cfg_q;
  str_state_t       st_q, st_d;
  logic             verdict;
  logic             in_acc;
  logic             out_valid_q;
  logic             accepted_q;
  logic [UnitW-1:0] count_q;
  logic             content_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_acc      = in_valid_i && in_ready_o;

  utf8tfc_decode u_decode (
    .st_i      (st_q),
    .cfg_i     (cfg_q),
    .byte_i    (in_text_byte_i),
    .st_o      (st_d),
    .verdict_o (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit_limit  <= UnitLimitReset;
      cfg_q.allow_lines <= 1'b0;
      cfg_q.req_content <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegUnitLimit:  cfg_q.unit_limit  <= cfg_data_i;
        RegAllowLines: cfg_q.allow_lines <= cfg_data_i[0];
        RegReqContent: cfg_q.req_content <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc && in_kind_i) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        if (in_kind_i) begin
          st_q <= '0;
        end else begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_kind_i) begin
      accepted_q <= verdict;
      count_q    <= st_q.units;
      content_q  <= st_q.content;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_accepted_o    = accepted_q;
  assign out_unit_count_o  = count_q;
  assign out_has_content_o = content_q;

endmodule

[design/utf8tfc_checker.sv]
// Port-level assertions for the UTF-8 text field checker, bound to the top.
// Depends on utf8tfc_pkg and utf8_text_field_checker_macros.svh.
`include "utf8_text_field_checker_macros.svh"

module utf8tfc_checker
  import utf8tfc_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             in_kind_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [UnitW-1:0] out_unit_count_o
);

  `UTF8TFC_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                       out_valid_o && $stable(out_unit_count_o))
  `UTF8TFC_ASSERT_NEXT(a_end_gives_result, in_valid_i && in_ready_o && in_kind_i, out_valid_o)
  `UTF8TFC_ASSERT_NEXT(a_byte_no_result,
                       in_valid_i && in_ready_o && !in_kind_i && (!out_valid_o || out_ready_i),
                       !out_valid_o)
  `UTF8TFC_ASSERT_NOW(a_stall_only_on_full, !in_ready_o, out_valid_o && !out_ready_i)

endmodule

bind utf8_text_field_checker utf8tfc_checker u_utf8tfc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_o       (in_ready_o),
  .in_kind_i        (in_kind_i),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .out_unit_count_o (out_unit_count_o)
);

[tb/testbench.sv]
// Self-checking testbench for the UTF-8 text field checker: drives strings byte by
// byte, predicts each verdict and compares it with the block's result.
// Depends on utf8tfc_pkg and utf8_text_field_checker.
module testbench
  import utf8tfc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {KindByte = 1'b0, KindEnd = 1'b1} item_kind_e;

  typedef struct packed {
    logic             ok;
    logic [UnitW-1:0] units;
    logic             has_text;
  } verdict_t;

  localparam int CycleLimit   = 1_000_000;
  localparam int SettleCycles = 4;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               in_kind_i;
  logic [7:0]         in_text_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               out_accepted_o;
  logic [UnitW-1:0]   out_unit_count_o;
  logic               out_has_content_o;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  // Model of the string state and the registers
  logic [1:0]       seq_left   = '0;
  logic [CpW-1:0]   seq_acc    = '0;
  logic [UnitW-1:0] unit_total = '0;
  logic             str_failed = 1'b0;
  logic             str_text   = 1'b0;
  logic [UnitW-1:0] limit_reg  = UnitLimitReset;
  logic             lines_reg  = 1'b0;
  logic             need_reg   = 1'b1;

  verdict_t   expected_verdicts[$];
  logic [7:0] text_bytes[$];
  int         mismatches    = 0;
  int         cycle_count   = 0;
  int         items_sent    = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  int         hold_left     = 0;

  utf8_text_field_checker i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_kind_i,
    .in_text_byte_i,
    .out_valid_o,
    .out_ready_i,
    .out_accepted_o,
    .out_unit_count_o,
    .out_has_content_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic is_space(logic [CpW-1:0] c);
    return (c >= 21'd9 && c <= 21'd13) || c == 21'd32 || c == 21'hA0 || c == 21'h1680 ||
           (c >= 21'h2000 && c <= 21'h200A) || c == 21'h2028 || c == 21'h2029 ||
           c == 21'h202F || c == 21'h205F || c == 21'h3000 || c == 21'hFEFF;
  endfunction

  function automatic void close_code_point(logic [CpW-1:0] c);
    logic [UnitW:0] sum;
    logic           ctrl_ok;
    sum = {1'b0, unit_total} + ((c >= CpSuppBase) ? 17'd2 : 17'd1);
    ctrl_ok = lines_reg && (c == CpTab || c == CpLf || c == CpCr);
    unit_total = sum[UnitW] ? UnitMax : sum[UnitW-1:0];
    if (sum > {1'b0, limit_reg} || c == CpDel || (c < 21'd32 && !ctrl_ok)) begin
      str_failed = 1'b1;
    end else if (!is_space(c)) begin
      str_text = 1'b1;
    end
  endfunction

  function automatic void fold_text_byte(logic kind, logic [7:0] b);
    verdict_t v;
    if (kind == KindEnd) begin
      v.ok       = !str_failed && seq_left == 2'd0 && !(need_reg && !str_text);
      v.units    = unit_total;
      v.has_text = str_text;
      expected_verdicts.push_back(v);
      seq_left   = '0;
      seq_acc    = '0;
      unit_total = '0;
      str_failed = 1'b0;
      str_text   = 1'b0;
    end else if (!str_failed) begin
      if (seq_left == 2'd0) begin
        if (b >= 8'hF0) begin
          seq_left = 2'd3;
          seq_acc  = CpW'(b[2:0]);
        end else if (b >= 8'hE0) begin
          seq_left = 2'd2;
          seq_acc  = CpW'(b[3:0]);
        end else if (b >= 8'hC0) begin
          seq_left = 2'd1;
          seq_acc  = CpW'(b[4:0]);
        end else begin
          close_code_point(CpW'(b));
        end
      end else begin
        seq_acc  = {seq_acc[CpW-7:0], b[5:0]};
        seq_left = seq_left - 2'd1;
        if (seq_left == 2'd0) begin
          close_code_point(seq_acc);
          seq_acc = '0;
        end
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [UnitW-1:0] want, logic [UnitW-1:0] got);
    $display("%0t: verdict %s: want %0h got %0h", $time, what, want, got);
    mismatches++;
  endtask

  task automatic check_verdict();
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch("with none pending", '0, out_unit_count_o);
    end else begin
      want = expected_verdicts.pop_front();
      if (out_accepted_o !== want.ok)
        report_mismatch("accepted", UnitW'(want.ok), UnitW'(out_accepted_o));
      if (out_unit_count_o !== want.units)
        report_mismatch("unit_count", want.units, out_unit_count_o);
      if (out_has_content_o !== want.has_text)
        report_mismatch("has_content", UnitW'(want.has_text), UnitW'(out_has_content_o));
    end
  endtask

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst_ni) begin
      if (out_valid_o && out_ready_i) check_verdict();
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          RegUnitLimit:  limit_reg = cfg_data_i[UnitW-1:0];
          RegAllowLines: lines_reg = cfg_data_i[0];
          RegReqContent: need_reg  = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) fold_text_byte(in_kind_i, in_text_byte_i);
    end
  end

  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      out_ready_i <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(logic kind, logic [7:0] b);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_kind_i      <= kind;
    in_text_byte_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  task automatic send_text();
    foreach (text_bytes[i]) send_item(KindByte, text_bytes[i]);
    send_item(KindEnd, 8'($urandom_range(255)));
    text_bytes.delete();
  endtask

  // drop the input and wait until every verdict is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDatW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_config(logic [UnitW-1:0] lim, logic lines, logic need);
    wait_idle();
    write_reg(RegUnitLimit, CfgDatW'(lim));
    write_reg(RegAllowLines, CfgDatW'(lines));
    write_reg(RegReqContent, CfgDatW'(need));
  endtask

  function automatic void add_code_point(logic [CpW-1:0] cp);
    if (cp < 21'h80) begin
      text_bytes.push_back(cp[7:0]);
    end else if (cp < 21'h800) begin
      text_bytes.push_back({3'b110, cp[10:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      text_bytes.push_back({4'b1110, cp[15:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      text_bytes.push_back({5'b11110, cp[20:18]});
      text_bytes.push_back({2'b10, cp[17:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end
  endfunction

  function automatic logic [CpW-1:0] pick_space();
    case ($urandom_range(0, 11))
      0:       return CpW'($urandom_range(9, 13));
      1:       return 21'd32;
      2:       return 21'hA0;
      3:       return 21'h1680;
      4:       return CpW'($urandom_range(32'h2000, 32'h200A));
      5:       return 21'h2028;
      6:       return 21'h2029;
      7:       return 21'h202F;
      8:       return 21'h205F;
      9:       return 21'h3000;
      10:      return 21'hFEFF;
      default: return CpW'($urandom_range(9, 13));
    endcase
  endfunction

  task automatic build_random_text();
    int n;
    int pick;
    n = ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 35) add_code_point(CpW'($urandom_range(8'h21, 8'h7E)));
      else if (pick < 45) add_code_point(pick_space());
      else if (pick < 52)
        add_code_point($urandom_range(7) == 0 ? CpDel : CpW'($urandom_range(0, 31)));
      else if (pick < 65) add_code_point(CpW'($urandom_range(32'h80, 32'h7FF)));
      else if (pick < 78) add_code_point(CpW'($urandom_range(32'h800, 32'hFFFF)));
      else if (pick < 86) add_code_point(CpW'($urandom_range(32'h10000, 32'h1FFFFF)));
      else if (pick < 93) text_bytes.push_back(8'($urandom_range(255)));
      else begin
        text_bytes.push_back(8'($urandom_range(8'hF8, 8'hFF)));
        repeat ($urandom_range(0, 3)) text_bytes.push_back(8'($urandom_range(255)));
      end
    end
    if (text_bytes.size() != 0 && $urandom_range(99) < 8) void'(text_bytes.pop_back());
  endtask

  task automatic random_config();
    logic [UnitW-1:0] lim;
    case ($urandom_range(0, 4))
      0:       lim = '0;
      1:       lim = UnitW'($urandom_range(1, 8));
      2:       lim = UnitW'($urandom_range(9, 60));
      3:       lim = UnitW'($urandom_range(61, 65534));
      default: lim = UnitMax;
    endcase
    set_config(lim, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic test_special_cases();
    send_text();
    text_bytes = '{8'h41, 8'hFF, 8'hBF, 8'hBF, 8'hBF, 8'h80};
    send_text();
    text_bytes = '{8'hC3, 8'h29, 8'h7F, 8'h41};
    send_text();
    text_bytes = '{8'h20, 8'hE2, 8'h80};
    send_text();
    text_bytes = '{8'hC0, 8'h80};
    send_text();
    text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
  endtask

  task automatic test_limits();
    set_config('0, 1'b1, 1'b0);
    text_bytes = '{8'h61};
    send_text();
    send_text();
    set_config(16'd3, 1'b1, 1'b0);
    text_bytes = '{8'h09, 8'h0A, 8'h0D};
    send_text();
    text_bytes = '{8'h61, 8'h62, 8'h63, 8'h64};
    send_text();
    text_bytes = '{8'h1F};
    send_text();
    set_config(16'd2, 1'b0, 1'b1);
    text_bytes = '{8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text();
    text_bytes = '{8'h0A};
    send_text();
  endtask

  task automatic test_backpressure();
    wait_idle();
    hold_left = 300;
    repeat (30) begin
      build_random_text();
      send_text();
    end
    wait_idle();
  endtask

  task automatic test_random(int count);
    int goal;
    int strings;
    goal = items_sent + count;
    strings = 0;
    while (items_sent < goal) begin
      if (strings % 20 == 0) random_config();
      build_random_text();
      send_text();
      strings++;
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_kind_i      = 1'b0;
    in_text_byte_i = '0;
    out_ready_i    = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 18;
    recv_idle_pct = 71;
    test_special_cases();
    test_limits();
    test_backpressure();
    test_random(460);

    send_idle_pct = 71;
    recv_idle_pct = 18;
    test_random(460);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(480);

    wait_idle();
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
